/* hdl/md5_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Shared types, round constants and index functions of the MD5 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  typedef logic [3:0][31:0] md5_words_t;

  typedef struct packed {
    logic       wr_byte;
    logic       pad;
    logic       len;
    logic       zero_fill;
    logic [5:0] pos;
    logic [7:0] data;
  } md5_buf_ctrl_t;

  localparam logic [31:0] MD5_INIT_A = 32'h67452301;
  localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
  localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
  localparam logic [31:0] MD5_INIT_D = 32'h10325476;
  localparam logic [7:0]  MD5_PAD_BYTE = 8'h80;
  localparam logic [5:0]  MD5_LEN_POS = 6'd56;
  localparam logic [63:0] MD5_BYTE_BITS = 64'd8;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] md5_msg_index(input logic [5:0] idx);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = idx[3:0];
    unique case (idx[5:4])
      2'd0:    g = i4;
      2'd1:    g = i4 * 4'd5 + 4'd1;
      2'd2:    g = i4 * 4'd3 + 4'd5;
      default: g = i4 * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] idx);
    return MD5_S[{idx[5:4], idx[1:0]}];
  endfunction

endpackage

`default_nettype wire

/* hdl/md5_in_if.sv */
// ----------------------------------------------------------------------------
// MD5 message byte channel
// Valid/ready channel that carries a message byte, an end mark, or both.
// ----------------------------------------------------------------------------
`default_nettype none

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

`default_nettype wire

/* hdl/md5_out_if.sv */
// ----------------------------------------------------------------------------
// MD5 digest channel
// Valid/ready channel that carries the four little-endian digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  input ready);
  modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  output ready);
endinterface

`default_nettype wire

/* hdl/md5_digest_engine_core.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine core
// Byte-serial MD5 with one shared round unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                              Transaction
// in_i     in   data_byte[8], has_byte, last         one message byte or end mark
// out_o    out  digest_word0..digest_word3 [32]      one digest per message
//
// A byte item is taken while idle; the byte that fills a block then starts the 64
// rounds of the shared round unit and the chaining add.
// An end item runs padding and length insertion, the rounds and chaining add of
// each block compressed (one or two), and a load of the digest register.
// Reset is asynchronous: control state clears, chaining reloads MD5 init values.
// Input is taken only while idle; a held digest stalls only the next digest load.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_digest_engine_core
  import md5_pkg::*;
(
  input  wire clk_i,
  input  wire rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  state_e        state_q;
  md5_words_t    chain_q;
  md5_words_t    work_q;
  md5_words_t    work_d;
  logic [63:0]   bit_cnt_q;
  logic [5:0]    pos_q;
  logic [5:0]    rnd_q;
  logic          end_q;
  logic          pad_done_q;
  logic          len_done_q;
  logic          out_vld_q;
  md5_words_t    out_q;
  logic          in_acc;
  logic [31:0]   msg_word;
  md5_buf_ctrl_t buf_ctrl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    buf_ctrl.wr_byte   = in_acc && in_i.has_byte;
    buf_ctrl.pad       = (state_q == S_PAD);
    buf_ctrl.len       = (state_q == S_LEN);
    buf_ctrl.zero_fill = (pos_q >= MD5_LEN_POS);
    buf_ctrl.pos       = pos_q;
    buf_ctrl.data      = in_i.data_byte;
  end

  md5_blkbuf u_blkbuf (
    .clk_i     (clk_i),
    .ctrl_i    (buf_ctrl),
    .len_i     (bit_cnt_q),
    .rd_addr_i (md5_msg_index(rnd_q)),
    .rd_data_o (msg_word)
  );

  md5_round u_round (
    .work_i (work_q),
    .msg_i  (msg_word),
    .idx_i  (rnd_q),
    .work_o (work_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      chain_q    <= {MD5_INIT_D, MD5_INIT_C, MD5_INIT_B, MD5_INIT_A};
      work_q     <= '0;
      bit_cnt_q  <= '0;
      pos_q      <= '0;
      rnd_q      <= '0;
      end_q      <= 1'b0;
      pad_done_q <= 1'b0;
      len_done_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (out_vld_q && out_o.ready && (state_q != S_OUT)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            end_q <= in_i.last;
            if (in_i.has_byte) begin
              pos_q     <= pos_q + 6'd1;
              bit_cnt_q <= bit_cnt_q + MD5_BYTE_BITS;
            end
            if (in_i.has_byte && (pos_q == 6'd63)) begin
              work_q  <= chain_q;
              rnd_q   <= '0;
              state_q <= S_ROUND;
            end else if (in_i.last) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_done_q <= 1'b1;
          if (pos_q >= MD5_LEN_POS) begin
            work_q  <= chain_q;
            rnd_q   <= '0;
            state_q <= S_ROUND;
          end else begin
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          len_done_q <= 1'b1;
          work_q     <= chain_q;
          rnd_q      <= '0;
          state_q    <= S_ROUND;
        end
        S_ROUND: begin
          work_q <= work_d;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          for (int k = 0; k < 4; k++) begin
            chain_q[k] <= chain_q[k] + work_q[k];
          end
          work_q <= '0;
          priority if (!end_q) begin
            state_q <= S_IDLE;
          end else if (!pad_done_q) begin
            state_q <= S_PAD;
          end else if (!len_done_q) begin
            state_q <= S_LEN;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_q || out_o.ready) begin
            out_q      <= chain_q;
            out_vld_q  <= 1'b1;
            chain_q    <= {MD5_INIT_D, MD5_INIT_C, MD5_INIT_B, MD5_INIT_A};
            bit_cnt_q  <= '0;
            pos_q      <= '0;
            rnd_q      <= '0;
            end_q      <= 1'b0;
            pad_done_q <= 1'b0;
            len_done_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.digest_word0 = out_q[0];
  assign out_o.digest_word1 = out_q[1];
  assign out_o.digest_word2 = out_q[2];
  assign out_o.digest_word3 = out_q[3];

endmodule

`default_nettype wire

/* hdl/md5_round.sv */
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 step: auxiliary function, modular sum and rotate for a round index.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_round
  import md5_pkg::*;
(
  input  wire md5_words_t  work_i,
  input  wire logic [31:0] msg_i,
  input  wire logic [5:0]  idx_i,
  output      md5_words_t  work_o
);

  logic [31:0] a, b, c, d;
  logic [31:0] f;
  logic [31:0] t;
  logic [4:0]  s;
  logic [63:0] rot_wide;

  assign a = work_i[0];
  assign b = work_i[1];
  assign c = work_i[2];
  assign d = work_i[3];

  always_comb begin
    unique case (idx_i[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign t        = a + f + msg_i + MD5_K[idx_i];
  assign s        = md5_rot(idx_i);
  assign rot_wide = {t, t} << s;

  assign work_o[0] = d;
  assign work_o[1] = b + rot_wide[63:32];
  assign work_o[2] = b;
  assign work_o[3] = c;

endmodule

`default_nettype wire

/* hdl/md5_blkbuf.sv */
// ----------------------------------------------------------------------------
// MD5 block buffer
// Sixteen-word message block with byte writes, padding and length insertion.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_blkbuf
  import md5_pkg::*;
(
  input  wire                clk_i,
  input  wire md5_buf_ctrl_t ctrl_i,
  input  wire logic [63:0]   len_i,
  input  wire logic [3:0]    rd_addr_i,
  output      logic [31:0]   rd_data_o
);

  logic [31:0] mem_q [16];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_byte) begin
      mem_q[ctrl_i.pos[5:2]][ctrl_i.pos[1:0]*8 +: 8] <= ctrl_i.data;
    end
    if (ctrl_i.pad) begin
      for (int w = 0; w < 16; w++) begin
        for (int l = 0; l < 4; l++) begin
          if (6'(w * 4 + l) == ctrl_i.pos) begin
            mem_q[w][l*8 +: 8] <= MD5_PAD_BYTE;
          end else if (6'(w * 4 + l) > ctrl_i.pos) begin
            mem_q[w][l*8 +: 8] <= 8'h00;
          end
        end
      end
    end
    if (ctrl_i.len) begin
      if (ctrl_i.zero_fill) begin
        for (int w = 0; w < 14; w++) begin
          mem_q[w] <= 32'h0;
        end
      end
      mem_q[14] <= len_i[31:0];
      mem_q[15] <= len_i[63:32];
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule

`default_nettype wire
